// File: rtl/core/bgdh_pkg.sv
// Shared types and constants of the box ground-distance homography core.
`default_nettype none
package bgdh_pkg;

    // Default geometry
    localparam int DEF_IMAGE_HEIGHT     = 720;
    localparam int DEF_BOTTOM_MARGIN    = 40;
    localparam int DEF_PIXELS_PER_METER = 10;

    // Datapath widths
    localparam int PIX_W   = 12;   // box fields
    localparam int PT_W    = 14;   // point coordinates in half pixels
    localparam int COEF_W  = 32;   // Q12.20 coefficient
    localparam int PROD_W  = 47;   // coefficient times point coordinate
    localparam int SUM_W   = 49;   // u, v, w
    localparam int MAG_W   = 48;   // magnitude of u, v, w
    localparam int PPM_W   = 10;   // pixels per metre
    localparam int DEN_W   = MAG_W + PPM_W;   // scaled divisor
    localparam int NUM_W   = MAG_W + 17;      // shifted dividend plus rounding term
    localparam int QUOT_W  = 34;              // quotient bits kept before saturation
    localparam int CMP_W   = DEN_W + QUOT_W;  // widest shifted divisor
    localparam int DIST_W  = 32;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_H11_H12 = 3'd0,
        CFG_H13_H21 = 3'd1,
        CFG_H22_H23 = 3'd2,
        CFG_H31_H32 = 3'd3,
        CFG_H33     = 3'd4,
        CFG_OFFSET_X = 3'd5,
        CFG_OFFSET_Y = 3'd6
    } t_cfg_idx;

    // Status carried alongside the division lanes
    typedef struct packed {
        logic used_bottom;
        logic zero;
        logic neg_x;
        logic neg_y;
        logic ovf_x;
        logic ovf_y;
    } t_side;

endpackage
`default_nettype wire

// File: rtl/core/bgdh_divider.sv
// Pipelined restoring divider, two lanes sharing one divisor, one quotient bit per stage.
`default_nettype none
module bgdh_divider (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_en,
    input  wire                                i_valid,
    input  wire  [bgdh_pkg::NUM_W-1:0]         i_num_x,
    input  wire  [bgdh_pkg::NUM_W-1:0]         i_num_y,
    input  wire  [bgdh_pkg::DEN_W-1:0]         i_den,
    input  bgdh_pkg::t_side                    i_side,
    output logic                               o_valid,
    output logic [bgdh_pkg::QUOT_W-1:0]        o_quot_x,
    output logic [bgdh_pkg::QUOT_W-1:0]        o_quot_y,
    output bgdh_pkg::t_side                    o_side
);
    import bgdh_pkg::*;

    logic [NUM_W-1:0]  r_rem_x  [QUOT_W];
    logic [NUM_W-1:0]  r_rem_y  [QUOT_W];
    logic [QUOT_W-1:0] r_quot_x [QUOT_W];
    logic [QUOT_W-1:0] r_quot_y [QUOT_W];
    logic [DEN_W-1:0]  r_den    [QUOT_W];
    t_side             r_side   [QUOT_W];
    logic [QUOT_W-1:0] r_valid;

    genvar g;
    generate
        for (g = 0; g < QUOT_W; g++) begin : g_stage
            logic [NUM_W-1:0]  rem_x_in, rem_y_in, n_rem_x, n_rem_y;
            logic [QUOT_W-1:0] quot_x_in, quot_y_in;
            logic [DEN_W-1:0]  den_in;
            t_side             side_in;
            logic              valid_in;
            logic [CMP_W-1:0]  den_sh, rx_ext, ry_ext;
            logic              take_x, take_y;

            // Stage input: previous stage or the divider inputs
            if (g == 0) begin : g_first
                assign rem_x_in  = i_num_x;
                assign rem_y_in  = i_num_y;
                assign quot_x_in = '0;
                assign quot_y_in = '0;
                assign den_in    = i_den;
                assign side_in   = i_side;
                assign valid_in  = i_valid;
            end else begin : g_next
                assign rem_x_in  = r_rem_x[g-1];
                assign rem_y_in  = r_rem_y[g-1];
                assign quot_x_in = r_quot_x[g-1];
                assign quot_y_in = r_quot_y[g-1];
                assign den_in    = r_den[g-1];
                assign side_in   = r_side[g-1];
                assign valid_in  = r_valid[g-1];
            end

            // Compare against the divisor shifted to this bit and subtract
            always_comb begin
                den_sh  = CMP_W'(den_in) << (QUOT_W - 1 - g);
                rx_ext  = CMP_W'(rem_x_in);
                ry_ext  = CMP_W'(rem_y_in);
                take_x  = rx_ext >= den_sh;
                take_y  = ry_ext >= den_sh;
                n_rem_x = take_x ? NUM_W'(rx_ext - den_sh) : rem_x_in;
                n_rem_y = take_y ? NUM_W'(ry_ext - den_sh) : rem_y_in;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[g] <= 1'b0;
                end else if (i_en) begin
                    r_valid[g] <= valid_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem_x[g]  <= n_rem_x;
                    r_rem_y[g]  <= n_rem_y;
                    r_quot_x[g] <= quot_x_in | (QUOT_W'(take_x) << (QUOT_W - 1 - g));
                    r_quot_y[g] <= quot_y_in | (QUOT_W'(take_y) << (QUOT_W - 1 - g));
                    r_den[g]    <= den_in;
                    r_side[g]   <= side_in;
                end
            end
        end
    endgenerate

    assign o_valid  = r_valid[QUOT_W-1];
    assign o_quot_x = r_quot_x[QUOT_W-1];
    assign o_quot_y = r_quot_y[QUOT_W-1];
    assign o_side   = r_side[QUOT_W-1];

endmodule
`default_nettype wire

// File: rtl/core/box_ground_distance_homography_core.sv
// Top level of the box ground-distance homography core.
// Usage:
//  - Slave stream takes one bounding box per transfer; master stream returns one
//    ground position per box, in order.
//  - Config channel writes calibration registers by index (0..6); it is always
//    ready, indexes past the list are dropped. Write only while the pipe is empty.
//  - The point on the box (bottom or top edge centre) goes through the
//    homography, a rounded scaled division and a saturating offset add.
//  - From input transfer to output valid a box passes five stages of point,
//    product, sum, magnitude and rounding work, 34 divider stages (one
//    quotient bit each) and the saturation/output register.
//  - Throughput is one box per cycle while the output is not stalled.
//  - The whole pipe advances together: when the output holds a result that is
//    not taken, o_s_axis_tready drops and every stage holds; nothing is lost.
//  - Synchronous reset clears all valid bits and restores the register defaults.
`default_nettype none
module box_ground_distance_homography_core #(
    parameter int IMAGE_HEIGHT     = bgdh_pkg::DEF_IMAGE_HEIGHT,
    parameter int BOTTOM_MARGIN    = bgdh_pkg::DEF_BOTTOM_MARGIN,
    parameter int PIXELS_PER_METER = bgdh_pkg::DEF_PIXELS_PER_METER
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // box_x [11:0], box_y [23:12], box_width [35:24], box_height [47:36]
    input  wire  [47:0] i_s_axis_tdata,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // dist_x [31:0], dist_y [63:32]
    output logic [63:0] o_m_axis_tdata,
    // used_bottom [0], zero_divisor [1], saturated [2]
    output logic [2:0]  o_m_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [bgdh_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [63:0] i_cfg_data
);
    import bgdh_pkg::*;

    localparam int BOTTOM_LIMIT = IMAGE_HEIGHT - BOTTOM_MARGIN;
    localparam logic [PPM_W-1:0] PPM = PPM_W'(PIXELS_PER_METER);
    localparam logic signed [DIST_W:0] S32_MAX = (DIST_W+1)'(2147483647);
    localparam logic signed [DIST_W:0] S32_MIN = -(DIST_W+1)'(33'sd2147483648);

    // Configuration registers
    logic [63:0] r_h11_h12, r_h13_h21, r_h22_h23, r_h31_h32;
    logic [31:0] r_h33, r_offset_x, r_offset_y;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h11_h12  <= 64'h0010_0000_0000_0000;
            r_h13_h21  <= '0;
            r_h22_h23  <= 64'h0010_0000_0000_0000;
            r_h31_h32  <= '0;
            r_h33      <= 32'h0010_0000;
            r_offset_x <= 32'hFFF5_07AE;
            r_offset_y <= 32'h0021_0000;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_H11_H12:  r_h11_h12  <= i_cfg_data;
                CFG_H13_H21:  r_h13_h21  <= i_cfg_data;
                CFG_H22_H23:  r_h22_h23  <= i_cfg_data;
                CFG_H31_H32:  r_h31_h32  <= i_cfg_data;
                CFG_H33:      r_h33      <= i_cfg_data[31:0];
                CFG_OFFSET_X: r_offset_x <= i_cfg_data[31:0];
                CFG_OFFSET_Y: r_offset_y <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Global advance: output register empty or being drained
    logic en;
    assign en              = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    // Stage 1: reference point and edge choice
    logic [PIX_W-1:0] in_x, in_y, in_w, in_h;
    logic [PIX_W:0]   bottom;
    logic             n_use_bottom;
    logic [PT_W-1:0]  n_px, n_py;
    logic             r_v1, r_ub1;
    logic [PT_W-1:0]  r_px, r_py;

    always_comb begin
        in_x         = i_s_axis_tdata[11:0];
        in_y         = i_s_axis_tdata[23:12];
        in_w         = i_s_axis_tdata[35:24];
        in_h         = i_s_axis_tdata[47:36];
        bottom       = (PIX_W+1)'(in_y) + (PIX_W+1)'(in_h);
        n_use_bottom = int'(bottom) < BOTTOM_LIMIT;
        n_px         = PT_W'({in_x, 1'b0}) + PT_W'(in_w);
        n_py         = n_use_bottom ? PT_W'({bottom, 1'b0}) : PT_W'({in_y, 1'b0});
    end

    // Stage 2: coefficient products
    logic signed [PROD_W-1:0] r_p11, r_p12, r_p21, r_p22, r_p31, r_p32;
    logic [COEF_W-1:0]        r_c13, r_c23, r_c33;
    logic                     r_v2, r_ub2;
    logic signed [PT_W:0]     px_s, py_s;
    logic signed [PROD_W-1:0] px_w, py_w;

    assign px_s = {1'b0, r_px};
    assign py_s = {1'b0, r_py};
    assign px_w = PROD_W'(px_s);
    assign py_w = PROD_W'(py_s);

    // Stage 3: projective sums
    logic signed [SUM_W-1:0] r_u, r_v, r_w;
    logic                    r_v3, r_ub3;

    // Stage 4: magnitudes, signs and scaled divisor
    logic [MAG_W-1:0] r_mag_u, r_mag_v;
    logic [DEN_W-1:0] r_den4;
    t_side            r_side4;
    logic             r_v4;

    // Stage 5: rounding term and quotient overflow test
    logic [NUM_W-1:0] r_num_x, r_num_y;
    logic [DEN_W-1:0] r_den5;
    t_side            r_side5;
    logic             r_v5;
    logic [NUM_W-1:0] n_num_x, n_num_y;
    logic [CMP_W-1:0] den_top;
    t_side            n_side5;

    always_comb begin
        n_num_x       = {r_mag_u, 16'b0} + NUM_W'(r_den4 >> 1);
        n_num_y       = {r_mag_v, 16'b0} + NUM_W'(r_den4 >> 1);
        den_top       = {r_den4, QUOT_W'(0)};
        n_side5       = r_side4;
        n_side5.ovf_x = CMP_W'(n_num_x) >= den_top;
        n_side5.ovf_y = CMP_W'(n_num_y) >= den_top;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_s_axis_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // stage 1
            r_px  <= n_px;
            r_py  <= n_py;
            r_ub1 <= n_use_bottom;
            // stage 2
            r_p11 <= PROD_W'($signed(r_h11_h12[63:32]) * px_w);
            r_p12 <= PROD_W'($signed(r_h11_h12[31:0])  * py_w);
            r_p21 <= PROD_W'($signed(r_h13_h21[31:0])  * px_w);
            r_p22 <= PROD_W'($signed(r_h22_h23[63:32]) * py_w);
            r_p31 <= PROD_W'($signed(r_h31_h32[63:32]) * px_w);
            r_p32 <= PROD_W'($signed(r_h31_h32[31:0])  * py_w);
            r_c13 <= r_h13_h21[63:32];
            r_c23 <= r_h22_h23[31:0];
            r_c33 <= r_h33;
            r_ub2 <= r_ub1;
            // stage 3: constant terms enter doubled
            r_u   <= SUM_W'(r_p11) + SUM_W'(r_p12)
                     + $signed({{(SUM_W-COEF_W-1){r_c13[COEF_W-1]}}, r_c13, 1'b0});
            r_v   <= SUM_W'(r_p21) + SUM_W'(r_p22)
                     + $signed({{(SUM_W-COEF_W-1){r_c23[COEF_W-1]}}, r_c23, 1'b0});
            r_w   <= SUM_W'(r_p31) + SUM_W'(r_p32)
                     + $signed({{(SUM_W-COEF_W-1){r_c33[COEF_W-1]}}, r_c33, 1'b0});
            r_ub3 <= r_ub2;
            // stage 4
            r_mag_u <= r_u[SUM_W-1] ? MAG_W'(-r_u) : MAG_W'(r_u);
            r_mag_v <= r_v[SUM_W-1] ? MAG_W'(-r_v) : MAG_W'(r_v);
            r_den4  <= DEN_W'(r_w[SUM_W-1] ? MAG_W'(-r_w) : MAG_W'(r_w)) * DEN_W'(PPM);
            r_side4 <= '{used_bottom: r_ub3,
                         zero:        (r_w == '0),
                         neg_x:       r_u[SUM_W-1] ^ r_w[SUM_W-1],
                         neg_y:       r_v[SUM_W-1] ^ r_w[SUM_W-1],
                         ovf_x:       1'b0,
                         ovf_y:       1'b0};
            // stage 5
            r_num_x <= n_num_x;
            r_num_y <= n_num_y;
            r_den5  <= r_den4;
            r_side5 <= n_side5;
        end
    end

    // Division lanes
    logic              div_valid;
    logic [QUOT_W-1:0] div_qx, div_qy;
    t_side             div_side;

    bgdh_divider u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (r_v5),
        .i_num_x  (r_num_x),
        .i_num_y  (r_num_y),
        .i_den    (r_den5),
        .i_side   (r_side5),
        .o_valid  (div_valid),
        .o_quot_x (div_qx),
        .o_quot_y (div_qy),
        .o_side   (div_side)
    );

    // Final stage: sign, offset and saturation
    logic signed [QUOT_W+1:0] gx, gy;
    logic signed [QUOT_W+2:0] sum_x, sum_y;
    logic [DIST_W-1:0]        n_dx, n_dy;
    logic                     n_sat;

    always_comb begin
        gx    = div_side.neg_x ? -$signed({2'b0, div_qx}) : $signed({2'b0, div_qx});
        gy    = div_side.neg_y ? -$signed({2'b0, div_qy}) : $signed({2'b0, div_qy});
        sum_x = (QUOT_W+3)'(gx) + (QUOT_W+3)'($signed(r_offset_x));
        sum_y = (QUOT_W+3)'($signed(r_offset_y)) - (QUOT_W+3)'(gy);
        n_sat = 1'b0;
        // lateral
        if (div_side.ovf_x) begin
            n_dx  = div_side.neg_x ? DIST_W'(S32_MIN) : DIST_W'(S32_MAX);
            n_sat = 1'b1;
        end else if (sum_x > (QUOT_W+3)'(S32_MAX)) begin
            n_dx  = DIST_W'(S32_MAX);
            n_sat = 1'b1;
        end else if (sum_x < (QUOT_W+3)'(S32_MIN)) begin
            n_dx  = DIST_W'(S32_MIN);
            n_sat = 1'b1;
        end else begin
            n_dx  = DIST_W'(sum_x);
        end
        // longitudinal, Y subtracted
        if (div_side.ovf_y) begin
            n_dy  = div_side.neg_y ? DIST_W'(S32_MAX) : DIST_W'(S32_MIN);
            n_sat = 1'b1;
        end else if (sum_y > (QUOT_W+3)'(S32_MAX)) begin
            n_dy  = DIST_W'(S32_MAX);
            n_sat = 1'b1;
        end else if (sum_y < (QUOT_W+3)'(S32_MIN)) begin
            n_dy  = DIST_W'(S32_MIN);
            n_sat = 1'b1;
        end else begin
            n_dy  = DIST_W'(sum_y);
        end
        // zero weight forces zeros
        if (div_side.zero) begin
            n_dx  = '0;
            n_dy  = '0;
            n_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_axis_tvalid <= 1'b0;
        end else if (en) begin
            o_m_axis_tvalid <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_m_axis_tdata <= {n_dy, n_dx};
            o_m_axis_tuser <= {n_sat, div_side.zero, div_side.used_bottom};
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/bgdh_checker.sv
// Port-level checks of the box ground-distance homography core, bound to the top level.
`default_nettype none
module bgdh_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_s_axis_tready,
    input wire [63:0] o_m_axis_tdata,
    input wire [2:0]  o_m_axis_tuser,
    input wire        o_m_axis_tvalid,
    input wire        i_m_axis_tready
);
    // A waiting result holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> $stable(o_m_axis_tdata))
        else $error("output payload changed while stalled");

    // A stalled output stops intake
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input accepted while output stalled");

    // Zero weight gives zero distances and no saturation
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[1]) |->
            (o_m_axis_tdata == 64'd0 && !o_m_axis_tuser[2]))
        else $error("zero divisor with non-zero result");

    // Saturation shows as a range limit in one of the distances
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[2]) |->
            (o_m_axis_tdata[31:0] == 32'h7FFF_FFFF || o_m_axis_tdata[31:0] == 32'h8000_0000
             || o_m_axis_tdata[63:32] == 32'h7FFF_FFFF
             || o_m_axis_tdata[63:32] == 32'h8000_0000))
        else $error("saturation flag without clamped distance");

    // Nothing leaves the pipe right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind box_ground_distance_homography_core bgdh_checker u_bgdh_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready)
);
`default_nettype wire

// File: test/box_ground_distance_checker.sv
// Checker for the box ground-distance core: watches every channel, predicts, compares.
`default_nettype none
module box_ground_distance_checker #(
    parameter int IMAGE_HEIGHT     = bgdh_pkg::DEF_IMAGE_HEIGHT,
    parameter int BOTTOM_MARGIN    = bgdh_pkg::DEF_BOTTOM_MARGIN,
    parameter int PIXELS_PER_METER = bgdh_pkg::DEF_PIXELS_PER_METER
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire  [47:0] i_s_tdata,
    input  wire         i_s_tvalid,
    input  wire         i_s_tready,
    input  wire  [63:0] i_m_tdata,
    input  wire  [2:0]  i_m_tuser,
    input  wire         i_m_tvalid,
    input  wire         i_m_tready,
    input  wire         i_cfg_valid,
    input  wire         i_cfg_ready,
    input  wire  [bgdh_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [63:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_results
);
    import bgdh_pkg::*;

    typedef struct packed {
        logic [31:0] dist_x;
        logic [31:0] dist_y;
        logic        used_bottom;
        logic        zero_divisor;
        logic        saturated;
    } t_ground;

    logic [63:0] calib [7];
    t_ground     ground_queue [$];

    assign o_pending = ground_queue.size();

    function automatic longint sx32(logic [31:0] v);
        return longint'($signed(v));
    endfunction

    // rounded |num|*65536 / (|den|*ppm), half away from zero, sign restored
    function automatic longint metre_div(longint num, longint den);
        logic [63:0] n, d, q;
        n = 64'(num < 0 ? -num : num) << 16;
        d = 64'(den < 0 ? -den : den) * 64'(PIXELS_PER_METER);
        q = (n + d / 2) / d;
        return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [31:0] clamp_s32(longint v, ref logic sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic t_ground predict_ground(logic [47:0] box);
        longint bx, by, bw, bh, btm, px, py, u, v, w;
        t_ground g;
        logic sat;
        bx = box[11:0];
        by = box[23:12];
        bw = box[35:24];
        bh = box[47:36];
        btm = by + bh;
        g = '0;
        sat = 1'b0;
        g.used_bottom = (longint'(IMAGE_HEIGHT) - btm) > longint'(BOTTOM_MARGIN);
        px = 2 * bx + bw;
        py = 2 * (g.used_bottom ? btm : by);
        u = sx32(calib[CFG_H11_H12][63:32]) * px + sx32(calib[CFG_H11_H12][31:0]) * py
            + 2 * sx32(calib[CFG_H13_H21][63:32]);
        v = sx32(calib[CFG_H13_H21][31:0]) * px + sx32(calib[CFG_H22_H23][63:32]) * py
            + 2 * sx32(calib[CFG_H22_H23][31:0]);
        w = sx32(calib[CFG_H31_H32][63:32]) * px + sx32(calib[CFG_H31_H32][31:0]) * py
            + 2 * sx32(calib[CFG_H33][31:0]);
        g.zero_divisor = (w == 0);
        if (w != 0) begin
            g.dist_x = clamp_s32(metre_div(u, w) + sx32(calib[CFG_OFFSET_X][31:0]), sat);
            g.dist_y = clamp_s32(sx32(calib[CFG_OFFSET_Y][31:0]) - metre_div(v, w), sat);
        end
        g.saturated = sat;
        return g;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h, want %h", what, got, want);
        o_errors++;
    endtask

    // track config, boxes and results on each clock edge
    always @(posedge i_clk) begin
        t_ground want;
        if (!i_rst_n) begin
            calib[CFG_H11_H12]  <= 64'd4503599627370496;
            calib[CFG_H13_H21]  <= 64'd0;
            calib[CFG_H22_H23]  <= 64'd4503599627370496;
            calib[CFG_H31_H32]  <= 64'd0;
            calib[CFG_H33]      <= 64'd1048576;
            calib[CFG_OFFSET_X] <= 64'(32'(-718930));
            calib[CFG_OFFSET_Y] <= 64'd2162688;
            ground_queue.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready && i_cfg_index <= CFG_OFFSET_Y)
                calib[i_cfg_index] <= (i_cfg_index >= CFG_H33) ? {32'd0, i_cfg_data[31:0]}
                                                             : i_cfg_data;
            if (i_m_tvalid && i_m_tready) begin
                o_results++;
                if (ground_queue.size() == 0) begin
                    report_mismatch("result transfer with nothing expected",
                                    i_m_tdata[31:0], 32'd0);
                end else begin
                    want = ground_queue.pop_front();
                    if (i_m_tdata[31:0] !== want.dist_x)
                        report_mismatch("dist_x", i_m_tdata[31:0], want.dist_x);
                    if (i_m_tdata[63:32] !== want.dist_y)
                        report_mismatch("dist_y", i_m_tdata[63:32], want.dist_y);
                    if (i_m_tuser[0] !== want.used_bottom)
                        report_mismatch("used_bottom", 32'(i_m_tuser[0]), 32'(want.used_bottom));
                    if (i_m_tuser[1] !== want.zero_divisor)
                        report_mismatch("zero_divisor", 32'(i_m_tuser[1]),
                                        32'(want.zero_divisor));
                    if (i_m_tuser[2] !== want.saturated)
                        report_mismatch("saturated", 32'(i_m_tuser[2]), 32'(want.saturated));
                end
            end
            if (i_s_tvalid && i_s_tready)
                ground_queue.push_back(predict_ground(i_s_tdata));
        end
    end

    initial begin
        o_errors  = 0;
        o_results = 0;
    end
endmodule
`default_nettype wire

// File: test/testbench.sv
// Top of the box ground-distance testbench: stimulus, config phases and verdict.
`default_nettype none
module testbench;
    import bgdh_pkg::*;

    // register index past the end of the list
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

    logic        i_clk;
    logic        i_rst_n;
    logic [47:0] s_tdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [63:0] cfg_data;
    int          errors, pending, results;
    int          boxes_sent, settings;
    bit          no_idle;

    box_ground_distance_homography_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .o_m_axis_tdata(m_tdata), .o_m_axis_tuser(m_tuser), .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data)
    );

    box_ground_distance_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tdata(s_tdata), .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser), .i_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(12 * 600000);
        $display("DONE: errors detected");
        $finish;
    end

    // receiver back-pressure
    always @(posedge i_clk)
        m_tready <= no_idle || ($urandom_range(99) >= 26);

    function automatic logic [47:0] pack_box(int x, int y, int w, int h);
        return {12'(h), 12'(w), 12'(y), 12'(x)};
    endfunction

    // one box transfer, with random sender gaps first
    task automatic send_box(logic [47:0] box);
        while (!no_idle && $urandom_range(99) < 26) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= box;
        do @(posedge i_clk); while (!s_tready);
        boxes_sent++;
    endtask

    // one register write, after which cfg_valid drops on the config channel
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // pipe empty plus the latency margin before touching config
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (45) @(posedge i_clk);
    endtask

    task automatic write_all(logic [63:0] c0, logic [63:0] c1, logic [63:0] c2,
                             logic [63:0] c3, logic [31:0] h33, logic [31:0] ox,
                             logic [31:0] oy);
        write_reg(CFG_H11_H12, c0);
        write_reg(CFG_H13_H21, c1);
        write_reg(CFG_H22_H23, c2);
        write_reg(CFG_H31_H32, c3);
        write_reg(CFG_H33, {$urandom, h33});
        write_reg(CFG_OFFSET_X, {$urandom, ox});
        write_reg(CFG_OFFSET_Y, {$urandom, oy});
        settings++;
    endtask

    task automatic random_boxes(int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < 70)
                send_box(pack_box($urandom_range(1279), $urandom_range(719),
                                  $urandom_range(300, 1), $urandom_range(300, 1)));
            else
                send_box(48'({$urandom, $urandom}));
        end
    endtask

    task automatic directed_boxes();
        send_box(pack_box(0, 0, 0, 0));
        send_box(pack_box(4095, 4095, 4095, 4095));
        send_box(pack_box(640, 600, 50, 79));     // bottom at 679: bottom edge
        send_box(pack_box(640, 600, 50, 80));     // bottom at 680: top edge
        send_box(pack_box(640, 600, 50, 81));
        send_box(pack_box(100, 700, 30, 100));    // past the image bottom
        send_box(pack_box(4095, 0, 0, 0));
        send_box(pack_box(0, 0, 4095, 0));
        send_box(pack_box(0, 4095, 0, 0));
        send_box(pack_box(0, 0, 0, 4095));
        send_box(pack_box(2048, 2048, 2048, 2048));
        send_box(pack_box(1, 1, 1, 1));
    endtask

    logic [31:0] r32;

    initial begin
        i_rst_n   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_H11_H12;
        cfg_data  = '0;
        no_idle   = 1'b0;
        boxes_sent = 0;
        settings   = 1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset calibration
        directed_boxes();
        random_boxes(150);
        drain();

        // zero weight everywhere; index past the list must be dropped
        write_all(64'h0010_0000_0000_0000, 64'h0, 64'h0010_0000_0000_0000, 64'h0,
                  32'h0, 32'h0, 32'h0);
        write_reg(CFG_IDX_UNUSED, {$urandom, $urandom});
        directed_boxes();
        drain();

        // extreme coefficients and offsets: saturation both ways
        write_all(64'h7FFF_FFFF_8000_0000, 64'h7FFF_FFFF_8000_0000,
                  64'h8000_0000_7FFF_FFFF, 64'h0000_0000_0000_0000,
                  32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000);
        directed_boxes();
        random_boxes(100);
        drain();
        write_all(64'h8000_0000_8000_0000, 64'h8000_0000_8000_0000,
                  64'h8000_0000_8000_0000, 64'h8000_0000_8000_0000,
                  32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        random_boxes(100);
        drain();
        write_all('1, '1, '1, '1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_boxes(80);
        drain();

        // random calibrations; one phase runs without any idling
        for (int p = 0; p < 6; p++) begin
            if (p % 2 == 0)
                write_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                          {$urandom, $urandom}, $urandom, $urandom, $urandom);
            else begin
                r32 = 32'($urandom_range(4096)) - 32'd2048;
                write_all({32'h0010_0000 + r32, r32 << 4}, {r32 << 8, r32},
                          {32'h0010_0000 - r32, r32 << 6}, {r32, r32 >> 3},
                          32'h0010_0000 + (r32 << 10), $urandom, $urandom);
            end
            no_idle = (p == 3);
            random_boxes(160);
            drain();
            no_idle = 1'b0;
        end

        $display("Covered %0d boxes and %0d results over %0d calibration settings,",
                 boxes_sent, results, settings);
        $display("including zero weight, saturation and the bottom-margin boundary.");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
